// ----- src/header_signature_scanner_top_assert.svh -----
// Assertion macros for the header signature scanner checker.
`ifndef HEADER_SIGNATURE_SCANNER_TOP_ASSERT_SVH
`define HEADER_SIGNATURE_SCANNER_TOP_ASSERT_SVH

// Check cons in the same cycle whenever ante holds, outside reset.
`define HSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds, outside reset.
`define HSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hss_pkg.sv -----
// Shared types and constants for the header signature scanner.
package hss_pkg;

    localparam int SIGNATURE_LEN_DEF = 10;
    localparam int SIGNATURE_LEN_MAX = 10;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 64;
    localparam int SIG_LO_W = 64;
    localparam int SIG_HI_W = 16;
    localparam int SKIP_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_HIGH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LEN = CFG_IDX_W'(2);

    localparam logic [SIG_LO_W-1:0] SIG_LOW_RESET  = 64'h0000_0010_002A_4949;
    localparam logic [SIG_HI_W-1:0] SIG_HIGH_RESET = 16'h5243;
    localparam logic [SKIP_W-1:0]   SKIP_RESET     = 24'd1000000;

    typedef struct packed {
        logic [SIG_LO_W-1:0] sig_low;
        logic [SIG_HI_W-1:0] sig_high;
        logic [SKIP_W-1:0]   skip_len;
    } t_cfg;

    typedef struct packed {
        logic                hit;
        logic [OFFSET_W-1:0] offset;
    } t_hit;

endpackage

// ----- src/hss_if.sv -----
// Channel interfaces for input bytes, match results and configuration writes.
interface hss_in_if;
    logic                        valid;
    logic                        ready;
    logic [hss_pkg::BYTE_W-1:0]   data_byte;
    logic                        block_start;
    logic [hss_pkg::OFFSET_W-1:0] block_base;

    modport source (output valid, data_byte, block_start, block_base, input ready);
    modport sink   (input valid, data_byte, block_start, block_base, output ready);
endinterface

interface hss_out_if;
    logic                        valid;
    logic                        ready;
    logic [hss_pkg::OFFSET_W-1:0] match_offset;

    modport source (output valid, match_offset, input ready);
    modport sink   (input valid, match_offset, output ready);
endinterface

interface hss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hss_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [hss_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- src/hss_cfg.sv -----
// Configuration registers: signature bytes and skip length.
module hss_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0]  i_reg_index,
    input  logic [hss_pkg::CFG_DATA_W-1:0] i_wr_data,
    output hss_pkg::t_cfg                  o_cfg
);

    hss_pkg::t_cfg r_cfg;
    hss_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_reg_index)
                hss_pkg::CFG_SIG_LOW:  n_cfg.sig_low  = i_wr_data[hss_pkg::SIG_LO_W-1:0];
                hss_pkg::CFG_SIG_HIGH: n_cfg.sig_high = i_wr_data[hss_pkg::SIG_HI_W-1:0];
                hss_pkg::CFG_SKIP_LEN: n_cfg.skip_len = i_wr_data[hss_pkg::SKIP_W-1:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sig_low  <= hss_pkg::SIG_LOW_RESET;
            r_cfg.sig_high <= hss_pkg::SIG_HIGH_RESET;
            r_cfg.skip_len <= hss_pkg::SKIP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/hss_scan.sv -----
// Sliding-window signature compare with skip counter and offset tracking.
module hss_scan #(
    parameter int SIGNATURE_LEN = hss_pkg::SIGNATURE_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [hss_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_block_start,
    input  logic [hss_pkg::OFFSET_W-1:0] i_block_base,
    input  hss_pkg::t_cfg                i_cfg,
    output hss_pkg::t_hit                o_hit
);

    localparam int FILL_W = $clog2(SIGNATURE_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SIGNATURE_LEN);
    localparam logic [hss_pkg::OFFSET_W-1:0] BACK_START = hss_pkg::OFFSET_W'(SIGNATURE_LEN - 1);
    localparam logic [hss_pkg::OFFSET_W-1:0] BACK_NEXT  = hss_pkg::OFFSET_W'(SIGNATURE_LEN - 2);
    localparam int SIG_VEC_W = hss_pkg::SIG_HI_W + hss_pkg::SIG_LO_W;

    logic [hss_pkg::BYTE_W-1:0]   r_window [SIGNATURE_LEN];
    logic [hss_pkg::BYTE_W-1:0]   n_window [SIGNATURE_LEN];
    logic [FILL_W-1:0]            r_fill;
    logic [FILL_W-1:0]            n_fill;
    logic [hss_pkg::SKIP_W-1:0]   r_skip;
    logic [hss_pkg::SKIP_W-1:0]   n_skip;
    logic [hss_pkg::OFFSET_W-1:0] r_offset;
    logic [hss_pkg::OFFSET_W-1:0] n_offset;

    logic [SIG_VEC_W-1:0]         w_sig_vec;
    logic [FILL_W-1:0]            w_fill_cur;
    logic [FILL_W-1:0]            w_fill_inc;
    logic [hss_pkg::SKIP_W-1:0]   w_skip_cur;
    logic                         w_bytes_eq;
    logic                         w_match;
    logic [hss_pkg::OFFSET_W-1:0] w_hit_offset;

    assign w_sig_vec  = {i_cfg.sig_high, i_cfg.sig_low};
    assign w_fill_cur = i_block_start ? '0 : r_fill;
    assign w_skip_cur = i_block_start ? '0 : r_skip;
    assign w_fill_inc = (w_fill_cur < FILL_FULL) ? w_fill_cur + FILL_W'(1) : w_fill_cur;
    assign w_hit_offset = i_block_start ? i_block_base - BACK_START : r_offset - BACK_NEXT;

    always_comb begin
        for (int k = 0; k < SIGNATURE_LEN - 1; k++) begin
            n_window[k] = r_window[k + 1];
        end
        n_window[SIGNATURE_LEN - 1] = i_data_byte;
    end

    always_comb begin
        w_bytes_eq = 1'b1;
        for (int k = 0; k < SIGNATURE_LEN; k++) begin
            if (n_window[k] != w_sig_vec[hss_pkg::BYTE_W*k +: hss_pkg::BYTE_W]) begin
                w_bytes_eq = 1'b0;
            end
        end
    end

    assign w_match = (w_skip_cur == '0) && (w_fill_inc == FILL_FULL) && w_bytes_eq;

    always_comb begin
        n_offset = i_block_start ? i_block_base : r_offset + hss_pkg::OFFSET_W'(1);
        if (w_skip_cur != '0) begin
            n_skip = w_skip_cur - hss_pkg::SKIP_W'(1);
            n_fill = w_fill_cur;
        end else if (w_match) begin
            n_skip = i_cfg.skip_len;
            n_fill = '0;
        end else begin
            n_skip = '0;
            n_fill = w_fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_skip   <= '0;
            r_offset <= '0;
        end else if (i_accept) begin
            r_fill   <= n_fill;
            r_skip   <= n_skip;
            r_offset <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (w_skip_cur == '0)) begin
            r_window <= n_window;
        end
    end

    assign o_hit.hit    = i_accept && w_match;
    assign o_hit.offset = w_hit_offset;

endmodule

// ----- src/hss_obuf.sv -----
// Two-entry result buffer that drives the output channel.
module hss_obuf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hss_pkg::t_hit                i_hit,
    output logic                         o_can_accept,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [hss_pkg::OFFSET_W-1:0] o_match_offset
);

    logic [hss_pkg::OFFSET_W-1:0] r_slot [2];
    logic                         r_wptr;
    logic                         r_rptr;
    logic [1:0]                   r_count;
    logic                         w_pop;
    logic                         w_push;

    assign w_push = i_hit.hit;
    assign w_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_hit.offset;
        end
    end

    assign o_valid        = (r_count != 2'd0);
    assign o_can_accept   = (r_count != 2'd2);
    assign o_match_offset = r_slot[r_rptr];

endmodule

// ----- src/header_signature_scanner_top.sv -----
// Top level of the header signature scanner.
// Scans one byte per clock for a configurable file-header signature and reports the
// disk offset of each signature's first byte. A byte is taken in the cycle it is
// offered while the output buffer has room; the window compare, skip counter and
// offset update finish in that same cycle, and a match is presented on the output
// channel from the next cycle. A two-entry result buffer sits between the scanner
// and the output, so input keeps flowing at one byte per cycle while a result waits
// to be taken; input stalls only when both entries are full. Configuration writes are
// registered and always ready; write only while no byte is in flight.
module header_signature_scanner_top #(
    parameter int SIGNATURE_LEN = hss_pkg::SIGNATURE_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hss_cfg_if.sink   i_cfg,
    hss_in_if.sink    i_in,
    hss_out_if.source o_out
);

    hss_pkg::t_cfg w_cfg;
    hss_pkg::t_hit w_hit;
    logic          w_can_accept;
    logic          w_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_can_accept;
    assign w_accept    = i_in.valid && w_can_accept;

    hss_cfg u_hss_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_cfg.valid),
        .i_reg_index (i_cfg.reg_index),
        .i_wr_data   (i_cfg.wr_data),
        .o_cfg       (w_cfg)
    );

    hss_scan #(
        .SIGNATURE_LEN (SIGNATURE_LEN)
    ) u_hss_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_in.data_byte),
        .i_block_start (i_in.block_start),
        .i_block_base  (i_in.block_base),
        .i_cfg         (w_cfg),
        .o_hit         (w_hit)
    );

    hss_obuf u_hss_obuf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hit          (w_hit),
        .o_can_accept   (w_can_accept),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_match_offset (o_out.match_offset)
    );

endmodule

// ----- src/hss_checker.sv -----
// Port-level checker for the header signature scanner and its bind.
`include "header_signature_scanner_top_assert.svh"

module hss_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [hss_pkg::OFFSET_W-1:0] i_match_offset
);

    `HSS_ASSERT_NEXT(a_out_valid_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `HSS_ASSERT_NEXT(a_out_data_hold, i_out_valid && !i_out_ready, $stable(i_match_offset), "result changed while stalled")
    `HSS_ASSERT_SAME(a_idle_ready, !i_out_valid, i_in_ready, "input stalled with empty result buffer")
    `HSS_ASSERT_SAME(a_result_cause, $rose(i_out_valid), $past(i_in_valid && i_in_ready), "result without input transfer")

endmodule

bind header_signature_scanner_top hss_checker u_hss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_match_offset (o_out.match_offset)
);
